// File: rtl/sht_pkg.sv
// Package for the sparse histogram table: sizes, action and state codes,
// and the saturating add and ordering helpers used by the table logic.
// Depends on nothing.
package sht_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CAT_W    = 32;
  localparam int unsigned CNT_W    = 48;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [FILL_W-1:0] FILL_CAP  = FILL_W'(CAPACITY);

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_SET    = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_ZERO   = 3'd3,
    ACT_SORTC  = 3'd4,
    ACT_SORTN  = 3'd5,
    ACT_READ   = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_ZERO,
    ST_CHK,
    ST_KEY,
    ST_CMP,
    ST_PLACE,
    ST_MERGE,
    ST_RDW,
    ST_RESP
  } state_e;

  // Adds two counts and clamps at the largest count.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
  endfunction

  // True if entry r must stand after entry k.
  function automatic logic goes_after(input logic [CAT_W-1:0] rc,
                                      input logic [CNT_W-1:0] rn,
                                      input logic [CAT_W-1:0] kc,
                                      input logic [CNT_W-1:0] kn,
                                      input logic by_count);
    logic res;
    if (by_count && (rn != kn)) begin
      res = rn > kn;
    end else begin
      res = $signed(rc) > $signed(kc);
    end
    return res;
  endfunction

endpackage

// File: rtl/sparse_histogram_table_unit.sv
// Top level of the sparse histogram table: a table of (category, count)
// pairs held in two synchronous memories, driven by one action sequencer.
// Depends on sht_pkg.

// How to use this block:
// Each input transfer on the slave side carries one action in s_axis_tuser
// together with a category, a count and an entry index in s_axis_tdata.
// Every action yields exactly one result transfer on the master side,
// carrying the hit, table_full and sort_done flags, the read entry and the
// fill level after the action.
// The block works on one action at a time. Its state sits in a category
// memory and a count memory, each with one write port and one read port
// whose data comes in the cycle after the address; every table walk is a
// sequence of reads, compares and write-backs through those ports.
// Steps per action, from acceptance to the result register:
//   append, clear: done on acceptance; read: one memory read;
//   zero counts: one write per entry; add and set: a search that ends
//   early when the category is found, then a count update or an append;
//   sort by count: insertion sort, walking back one entry per cycle; sort
//   by category: a check pass, then if needed insertion sort and a merge.
// Reset empties the table; the memories need no clearing, since entries
// at or above the fill level are never used. A stalled receiver holds the
// result in the output register; the block finishes its next action and
// then waits until that register is free.
module sparse_histogram_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // category [31:0], count_value [79:32], entry_index [87:80]
  input  logic [87:0] s_axis_tdata,
  // action [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit [0], table_full [1], sort_done [2], entry_category [34:3],
  // entry_count [82:35], entries_used [91:83], zero [95:92]
  output logic [95:0] m_axis_tdata
);

  localparam int unsigned IW = sht_pkg::IDX_W;
  localparam int unsigned FW = sht_pkg::FILL_W;
  localparam int unsigned CW = sht_pkg::CAT_W;
  localparam int unsigned NW = sht_pkg::CNT_W;

  // Table memories.
  logic [CW-1:0] cat_mem [sht_pkg::CAPACITY];
  logic [NW-1:0] cnt_mem [sht_pkg::CAPACITY];

  logic [IW-1:0] raddr;
  logic [CW-1:0] rd_cat_q;
  logic [NW-1:0] rd_cnt_q;
  logic          wr_cat_en, wr_cnt_en;
  logic [IW-1:0] waddr;
  logic [CW-1:0] wcat;
  logic [NW-1:0] wcnt;

  always_ff @(posedge clk_i) begin
    if (wr_cat_en) begin
      cat_mem[waddr] <= wcat;
    end
    if (wr_cnt_en) begin
      cnt_mem[waddr] <= wcnt;
    end
    rd_cat_q <= cat_mem[raddr];
    rd_cnt_q <= cnt_mem[raddr];
  end

  // Sequencer state.
  sht_pkg::state_e  st_q, st_d;
  sht_pkg::action_e op_q, op_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] k_q, k_d;
  logic [FW-1:0] i_q, i_d;
  logic [FW-1:0] j_q, j_d;
  logic [FW-1:0] ma_q, ma_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          out_valid_q, out_valid_d;

  // Working registers.
  logic [CW-1:0] cat_q, cat_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] key_cat_q, key_cat_d;
  logic [NW-1:0] key_cnt_q, key_cnt_d;
  logic [CW-1:0] prev_cat_q, prev_cat_d;
  logic [CW-1:0] acc_cat_q, acc_cat_d;
  logic [NW-1:0] acc_cnt_q, acc_cnt_d;
  logic          w_hit_q, w_hit_d;
  logic          w_full_q, w_full_d;
  logic          w_sort_q, w_sort_d;
  logic [CW-1:0] w_rcat_q, w_rcat_d;
  logic [NW-1:0] w_rcnt_q, w_rcnt_d;
  logic [95:0]   out_data_q, out_data_d;

  // Shared conditions.
  logic          in_fire;
  logic          out_free;
  logic          scan_more;
  logic          srch_hit;
  logic          chk_break;
  logic          cmp_after;
  logic          next_more;
  logic          j_last;
  logic          fill_small;
  logic [FW-1:0] i_inc;
  logic [FW-1:0] j_dec;
  logic [FW-1:0] i_dec;
  logic [FW-1:0] j_dec2;

  assign s_axis_tready = (st_q == sht_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign scan_more     = k_q < fill_q;
  assign srch_hit      = pend_q && (rd_cat_q == cat_q);
  assign chk_break     = pend_q && (pidx_q != '0) &&
                         ($signed(prev_cat_q) >= $signed(rd_cat_q));
  assign cmp_after     = sht_pkg::goes_after(rd_cat_q, rd_cnt_q, key_cat_q, key_cnt_q,
                                             op_q == sht_pkg::ACT_SORTN);
  assign i_inc         = i_q + FW'(1);
  assign i_dec         = i_q - FW'(1);
  assign j_dec         = j_q - FW'(1);
  assign j_dec2        = j_q - FW'(2);
  assign next_more     = i_inc < fill_q;
  assign j_last        = (j_q == FW'(1));
  assign fill_small    = fill_q <= FW'(1);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sht_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (sht_pkg::action_e'(s_axis_tuser))
            sht_pkg::ACT_ADD,
            sht_pkg::ACT_SET:    st_d = sht_pkg::ST_SRCH;
            sht_pkg::ACT_ZERO:   st_d = sht_pkg::ST_ZERO;
            sht_pkg::ACT_SORTC:  st_d = fill_small ? sht_pkg::ST_RESP : sht_pkg::ST_CHK;
            sht_pkg::ACT_SORTN:  st_d = fill_small ? sht_pkg::ST_RESP : sht_pkg::ST_KEY;
            sht_pkg::ACT_READ:   st_d = sht_pkg::ST_RDW;
            default:             st_d = sht_pkg::ST_RESP;
          endcase
        end
      end
      sht_pkg::ST_SRCH: begin
        if (srch_hit || (!scan_more && !pend_q)) begin
          st_d = sht_pkg::ST_RESP;
        end
      end
      sht_pkg::ST_ZERO: begin
        if (!scan_more) begin
          st_d = sht_pkg::ST_RESP;
        end
      end
      sht_pkg::ST_CHK: begin
        if (chk_break) begin
          st_d = sht_pkg::ST_KEY;
        end else if (!scan_more && !pend_q) begin
          st_d = sht_pkg::ST_RESP;
        end
      end
      sht_pkg::ST_KEY: st_d = sht_pkg::ST_CMP;
      sht_pkg::ST_CMP,
      sht_pkg::ST_PLACE: begin
        if ((st_q == sht_pkg::ST_CMP) && cmp_after) begin
          st_d = j_last ? sht_pkg::ST_PLACE : sht_pkg::ST_CMP;
        end else if (next_more) begin
          st_d = sht_pkg::ST_KEY;
        end else if (op_q == sht_pkg::ACT_SORTN) begin
          st_d = sht_pkg::ST_RESP;
        end else begin
          st_d = sht_pkg::ST_MERGE;
        end
      end
      sht_pkg::ST_MERGE: begin
        if (!scan_more && !pend_q) begin
          st_d = sht_pkg::ST_RESP;
        end
      end
      sht_pkg::ST_RDW: st_d = sht_pkg::ST_RESP;
      sht_pkg::ST_RESP: begin
        if (out_free) begin
          st_d = sht_pkg::ST_IDLE;
        end
      end
      default: st_d = sht_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d        = op_q;
    fill_d      = fill_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    ma_d        = ma_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    out_valid_d = out_valid_q;
    cat_d       = cat_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    key_cat_d   = key_cat_q;
    key_cnt_d   = key_cnt_q;
    prev_cat_d  = prev_cat_q;
    acc_cat_d   = acc_cat_q;
    acc_cnt_d   = acc_cnt_q;
    w_hit_d     = w_hit_q;
    w_full_d    = w_full_q;
    w_sort_d    = w_sort_q;
    w_rcat_d    = w_rcat_q;
    w_rcnt_d    = w_rcnt_q;
    out_data_d  = out_data_q;
    raddr       = '0;
    wr_cat_en   = 1'b0;
    wr_cnt_en   = 1'b0;
    waddr       = '0;
    wcat        = '0;
    wcnt        = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      sht_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d     = sht_pkg::action_e'(s_axis_tuser);
          cat_d    = s_axis_tdata[31:0];
          cnt_d    = s_axis_tdata[79:32];
          idx_d    = s_axis_tdata[87:80];
          k_d      = '0;
          w_hit_d  = 1'b0;
          w_full_d = 1'b0;
          w_sort_d = 1'b0;
          w_rcat_d = '0;
          w_rcnt_d = '0;
          unique case (sht_pkg::action_e'(s_axis_tuser))
            sht_pkg::ACT_APPEND: begin
              if (fill_q == sht_pkg::FILL_CAP) begin
                w_full_d = 1'b1;
              end else begin
                wr_cat_en = 1'b1;
                wr_cnt_en = 1'b1;
                waddr     = fill_q[IW-1:0];
                wcat      = s_axis_tdata[31:0];
                wcnt      = s_axis_tdata[79:32];
                fill_d    = fill_q + FW'(1);
              end
            end
            sht_pkg::ACT_SORTN: begin
              i_d   = FW'(1);
              raddr = IW'(1);
            end
            sht_pkg::ACT_READ: begin
              raddr = s_axis_tdata[87:80];
            end
            sht_pkg::ACT_CLEAR: begin
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      sht_pkg::ST_SRCH: begin
        if (srch_hit) begin
          w_hit_d   = 1'b1;
          wr_cnt_en = 1'b1;
          waddr     = pidx_q;
          wcnt      = (op_q == sht_pkg::ACT_ADD) ? sht_pkg::sat_add(rd_cnt_q, cnt_q) : cnt_q;
        end else if (scan_more) begin
          raddr  = k_q[IW-1:0];
          pend_d = 1'b1;
          pidx_d = k_q[IW-1:0];
          k_d    = k_q + FW'(1);
        end else if (!pend_q) begin
          if (fill_q == sht_pkg::FILL_CAP) begin
            w_full_d = 1'b1;
          end else begin
            wr_cat_en = 1'b1;
            wr_cnt_en = 1'b1;
            waddr     = fill_q[IW-1:0];
            wcat      = cat_q;
            wcnt      = cnt_q;
            fill_d    = fill_q + FW'(1);
          end
        end
      end
      sht_pkg::ST_ZERO: begin
        if (scan_more) begin
          wr_cnt_en = 1'b1;
          waddr     = k_q[IW-1:0];
          wcnt      = '0;
          k_d       = k_q + FW'(1);
        end
      end
      sht_pkg::ST_CHK: begin
        if (chk_break) begin
          i_d   = FW'(1);
          raddr = IW'(1);
        end else begin
          if (pend_q) begin
            prev_cat_d = rd_cat_q;
          end
          if (scan_more) begin
            raddr  = k_q[IW-1:0];
            pend_d = 1'b1;
            pidx_d = k_q[IW-1:0];
            k_d    = k_q + FW'(1);
          end
        end
      end
      sht_pkg::ST_KEY: begin
        key_cat_d = rd_cat_q;
        key_cnt_d = rd_cnt_q;
        j_d       = i_q;
        raddr     = i_dec[IW-1:0];
      end
      sht_pkg::ST_CMP,
      sht_pkg::ST_PLACE: begin
        wr_cat_en = 1'b1;
        wr_cnt_en = 1'b1;
        waddr     = j_q[IW-1:0];
        if ((st_q == sht_pkg::ST_CMP) && cmp_after) begin
          wcat  = rd_cat_q;
          wcnt  = rd_cnt_q;
          j_d   = j_dec;
          raddr = j_dec2[IW-1:0];
        end else begin
          wcat = key_cat_q;
          wcnt = key_cnt_q;
          i_d  = i_inc;
          if (next_more) begin
            raddr = i_inc[IW-1:0];
          end else if (op_q == sht_pkg::ACT_SORTN) begin
            w_sort_d = 1'b1;
          end else begin
            k_d  = '0;
            ma_d = '0;
          end
        end
      end
      sht_pkg::ST_MERGE: begin
        if (pend_q) begin
          if (pidx_q == '0) begin
            acc_cat_d = rd_cat_q;
            acc_cnt_d = rd_cnt_q;
          end else if (rd_cat_q != acc_cat_q) begin
            wr_cat_en = 1'b1;
            wr_cnt_en = 1'b1;
            waddr     = ma_q[IW-1:0];
            wcat      = acc_cat_q;
            wcnt      = acc_cnt_q;
            ma_d      = ma_q + FW'(1);
            acc_cat_d = rd_cat_q;
            acc_cnt_d = rd_cnt_q;
          end else begin
            acc_cnt_d = sht_pkg::sat_add(acc_cnt_q, rd_cnt_q);
          end
        end
        if (scan_more) begin
          raddr  = k_q[IW-1:0];
          pend_d = 1'b1;
          pidx_d = k_q[IW-1:0];
          k_d    = k_q + FW'(1);
        end else if (!pend_q) begin
          wr_cat_en = 1'b1;
          wr_cnt_en = 1'b1;
          waddr     = ma_q[IW-1:0];
          wcat      = acc_cat_q;
          wcnt      = acc_cnt_q;
          fill_d    = ma_q + FW'(1);
          w_sort_d  = 1'b1;
        end
      end
      sht_pkg::ST_RDW: begin
        if ({1'b0, idx_q} < fill_q) begin
          w_rcat_d = rd_cat_q;
          w_rcnt_d = rd_cnt_q;
        end
      end
      sht_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0000, fill_q, w_rcnt_q, w_rcat_q, w_sort_q, w_full_q, w_hit_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sht_pkg::ST_IDLE;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    k_q        <= k_d;
    i_q        <= i_d;
    j_q        <= j_d;
    ma_q       <= ma_d;
    pidx_q     <= pidx_d;
    cat_q      <= cat_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    key_cat_q  <= key_cat_d;
    key_cnt_q  <= key_cnt_d;
    prev_cat_q <= prev_cat_d;
    acc_cat_q  <= acc_cat_d;
    acc_cnt_q  <= acc_cnt_d;
    w_hit_q    <= w_hit_d;
    w_full_q   <= w_full_d;
    w_sort_q   <= w_sort_d;
    w_rcat_q   <= w_rcat_d;
    w_rcnt_q   <= w_rcnt_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: tb/tb_sparse_histogram_table_unit.sv
// Self-checking testbench for sparse_histogram_table_unit: directed table walk,
// full-table corner cases and random traffic under varying stream stalls.
// Depends on sht_pkg and the sparse_histogram_table_unit RTL.
`timescale 1ns / 1ps

module tb_sparse_histogram_table_unit;

  localparam int unsigned IDLE_LIMIT = 400000;
  localparam logic [47:0] CNT_TOP = 48'hFFFF_FFFF_FFFF;

  // Packed from the top bit down, so hit lands in bit 0 of the result.
  typedef struct packed {
    logic [8:0]  used;
    logic [47:0] ecnt;
    logic [31:0] ecat;
    logic        sorted;
    logic        full;
    logic        hit;
  } hist_result_t;

  typedef struct {
    sht_pkg::action_e act;
    logic [31:0]      cat;
    logic [47:0]      cnt;
    logic [7:0]       idx;
    logic             typed;
    hist_result_t     res;
  } hist_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  sparse_histogram_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [31:0] shadow_cat [sht_pkg::CAPACITY];
  logic [47:0] shadow_cnt [sht_pkg::CAPACITY];
  int unsigned shadow_fill;

  hist_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  src_idle = 0;
  int unsigned  snk_idle = 0;
  int unsigned  quiet_cycles = 0;
  logic [31:0]  cat_pool [8];

  function automatic logic [47:0] clamp_sum(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? CNT_TOP : s[47:0];
  endfunction

  // True when entry x must stand behind entry y.
  function automatic logic ranks_behind(input logic [31:0] cx, input logic [47:0] nx,
                                        input logic [31:0] cy, input logic [47:0] ny,
                                        input logic by_count);
    if (by_count && nx != ny) return nx > ny;
    return $signed(cx) > $signed(cy);
  endfunction

  function automatic void order_shadow(input logic by_count);
    logic [31:0] c;
    logic [47:0] n;
    int j;
    for (int i = 1; i < shadow_fill; i++) begin
      c = shadow_cat[i];
      n = shadow_cnt[i];
      j = i;
      while (j > 0 && ranks_behind(shadow_cat[j-1], shadow_cnt[j-1], c, n, by_count)) begin
        shadow_cat[j] = shadow_cat[j-1];
        shadow_cnt[j] = shadow_cnt[j-1];
        j--;
      end
      shadow_cat[j] = c;
      shadow_cnt[j] = n;
    end
  endfunction

  function automatic logic append_shadow(input logic [31:0] c, input logic [47:0] n);
    if (shadow_fill >= sht_pkg::CAPACITY) return 1'b0;
    shadow_cat[shadow_fill] = c;
    shadow_cnt[shadow_fill] = n;
    shadow_fill++;
    return 1'b1;
  endfunction

  // Applies one action to the shadow table and returns the result it yields.
  function automatic hist_result_t apply_action(input sht_pkg::action_e a,
                                                input logic [31:0] c,
                                                input logic [47:0] n, input logic [7:0] ix);
    hist_result_t r;
    int unsigned i;
    int unsigned k;
    logic ascending;
    r = '0;
    case (a)
      sht_pkg::ACT_ADD, sht_pkg::ACT_SET: begin
        for (i = 0; i < shadow_fill; i++) if (shadow_cat[i] == c) break;
        if (i < shadow_fill) begin
          r.hit = 1'b1;
          shadow_cnt[i] = (a == sht_pkg::ACT_ADD) ? clamp_sum(shadow_cnt[i], n) : n;
        end else begin
          r.full = !append_shadow(c, n);
        end
      end
      sht_pkg::ACT_APPEND: r.full = !append_shadow(c, n);
      sht_pkg::ACT_ZERO: for (i = 0; i < shadow_fill; i++) shadow_cnt[i] = '0;
      sht_pkg::ACT_SORTC: begin
        ascending = 1'b1;
        for (i = 1; i < shadow_fill; i++)
          if ($signed(shadow_cat[i-1]) >= $signed(shadow_cat[i])) ascending = 1'b0;
        if (shadow_fill > 1 && !ascending) begin
          order_shadow(1'b0);
          k = 0;
          // Fold runs of equal categories into the first entry of the run.
          for (i = 1; i < shadow_fill; i++) begin
            if (shadow_cat[k] != shadow_cat[i]) begin
              k++;
              shadow_cat[k] = shadow_cat[i];
              shadow_cnt[k] = shadow_cnt[i];
            end else begin
              shadow_cnt[k] = clamp_sum(shadow_cnt[k], shadow_cnt[i]);
            end
          end
          shadow_fill = k + 1;
          r.sorted = 1'b1;
        end
      end
      sht_pkg::ACT_SORTN: if (shadow_fill > 1) begin
        order_shadow(1'b1);
        r.sorted = 1'b1;
      end
      sht_pkg::ACT_READ: if (ix < shadow_fill) begin
        r.ecat = shadow_cat[ix];
        r.ecnt = shadow_cnt[ix];
      end
      default: shadow_fill = 0;
    endcase
    r.used = 9'(shadow_fill);
    return r;
  endfunction

  // Sends one action; a typed result replaces the predicted one in the queue.
  task automatic send_action(input sht_pkg::action_e a, input logic [31:0] c,
                             input logic [47:0] n, input logic [7:0] ix,
                             input logic typed, input hist_result_t tres);
    hist_result_t r;
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ix, n, c};
    s_axis_tuser  <= a;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_action(a, c, n, ix);
    pending_results.push_back(typed ? tres : r);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] pick_count();
    case ($urandom_range(5))
      0:       return CNT_TOP - 48'($urandom_range(3));
      1:       return 48'({$urandom, $urandom}) & CNT_TOP;
      2:       return 48'd0;
      default: return 48'($urandom_range(1000));
    endcase
  endfunction

  task automatic send_random();
    sht_pkg::action_e a;
    logic [31:0]      c;
    logic [7:0]       ix;
    int unsigned      roll;
    roll = $urandom_range(99);
    if (shadow_fill > 40 && $urandom_range(3) == 0) a = sht_pkg::ACT_CLEAR;
    else if (roll < 28) a = sht_pkg::ACT_ADD;
    else if (roll < 46) a = sht_pkg::ACT_SET;
    else if (roll < 62) a = sht_pkg::ACT_APPEND;
    else if (roll < 84) a = sht_pkg::ACT_READ;
    else if (roll < 88) a = sht_pkg::ACT_ZERO;
    else if (roll < 93) a = sht_pkg::ACT_SORTC;
    else if (roll < 97) a = sht_pkg::ACT_SORTN;
    else a = sht_pkg::ACT_CLEAR;
    c  = ($urandom_range(3) == 0) ? $urandom : cat_pool[$urandom_range(7)];
    ix = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(shadow_fill + 1));
    send_action(a, c, pick_count(), ix, 1'b0, '0);
  endtask

  // Sink: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    hist_result_t got;
    hist_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[91:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
          $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
        if (got.full !== want.full)
          $display("%0t: table_full exp %b got %b", $time, want.full, got.full);
        if (got.sorted !== want.sorted)
          $display("%0t: sort_done exp %b got %b", $time, want.sorted, got.sorted);
        if (got.ecat !== want.ecat)
          $display("%0t: entry_category exp %h got %h", $time, want.ecat, got.ecat);
        if (got.ecnt !== want.ecnt)
          $display("%0t: entry_count exp %h got %h", $time, want.ecnt, got.ecnt);
        if (got.used !== want.used)
          $display("%0t: entries_used exp %0d got %0d", $time, want.used, got.used);
        if (m_axis_tdata[95:92] !== 4'd0)
          $display("%0t: pad bits exp %h got %h", $time, 4'd0, m_axis_tdata[95:92]);
        if (got !== want || m_axis_tdata[95:92] !== 4'd0) error_count++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("sparse_histogram_table_unit regression: fail");
      $finish;
    end
  end

  hist_row_t directed_rows[$];

  task automatic add_row(input sht_pkg::action_e a, input logic [31:0] c,
                         input logic [47:0] n, input logic [7:0] ix,
                         input logic typed, input hist_result_t r);
    hist_row_t row;
    row = '{a, c, n, ix, typed, r};
    directed_rows.push_back(row);
  endtask

  initial begin
    hist_result_t none;
    hist_result_t top_read;
    none = '0;
    top_read = '0;
    top_read.ecat = 32'h8000_0000;
    top_read.ecnt = CNT_TOP;
    top_read.used = 9'd1;
    for (int i = 0; i < 8; i++) cat_pool[i] = $urandom;
    cat_pool[0] = 32'h8000_0000;
    cat_pool[1] = 32'h7FFF_FFFF;
    shadow_fill = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset state, field extremes, saturation, duplicates,
    // sorting with merge, out-of-range reads and the empty-table cases.
    add_row(sht_pkg::ACT_READ,   32'h0,         48'h0,   8'd0,   1'b1, none);
    add_row(sht_pkg::ACT_SORTC,  32'h0,         48'h0,   8'd0,   1'b1, none);
    add_row(sht_pkg::ACT_SORTN,  32'h0,         48'h0,   8'd0,   1'b1, none);
    add_row(sht_pkg::ACT_ZERO,   32'h0,         48'h0,   8'd0,   1'b1, none);
    add_row(sht_pkg::ACT_ADD,    32'h8000_0000, CNT_TOP, 8'hFF,  1'b0, none);
    add_row(sht_pkg::ACT_ADD,    32'h8000_0000, 48'd1,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_READ,   32'hFFFF_FFFF, CNT_TOP, 8'd0,   1'b1, top_read);
    add_row(sht_pkg::ACT_SET,    32'h7FFF_FFFF, 48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_SET,    32'h7FFF_FFFF, 48'd5,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_APPEND, 32'h7FFF_FFFF, CNT_TOP, 8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_APPEND, 32'h0,         48'd3,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_SORTN,  32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_READ,   32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_SORTC,  32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_SORTC,  32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_READ,   32'h0,         48'd0,   8'd2,   1'b0, none);
    add_row(sht_pkg::ACT_READ,   32'h0,         48'd0,   8'd255, 1'b0, none);
    add_row(sht_pkg::ACT_SORTN,  32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_ZERO,   32'h0,         48'd0,   8'd0,   1'b0, none);
    add_row(sht_pkg::ACT_READ,   32'h0,         48'd0,   8'd1,   1'b0, none);
    add_row(sht_pkg::ACT_CLEAR,  32'h0,         48'd0,   8'd0,   1'b1, none);
    foreach (directed_rows[i])
      send_action(directed_rows[i].act, directed_rows[i].cat, directed_rows[i].cnt,
                  directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].res);
    drain_results();

    // Fill the table to capacity, then hit the full-table cases and sort
    // the largest table once each way.
    for (int i = 0; i < sht_pkg::CAPACITY; i++)
      send_action(sht_pkg::ACT_APPEND, $urandom, pick_count(), 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_ADD,    32'h1234_5678, 48'd1, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_SET,    32'h1234_5679, 48'd1, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_APPEND, shadow_cat[3], 48'd1, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_ADD,    shadow_cat[5], CNT_TOP, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_READ,   32'h0, 48'd0, 8'd255, 1'b0, none);
    send_action(sht_pkg::ACT_SORTN,  32'h0, 48'd0, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_SORTC,  32'h0, 48'd0, 8'd0, 1'b0, none);
    send_action(sht_pkg::ACT_READ,   32'h0, 48'd0, 8'd128, 1'b0, none);
    send_action(sht_pkg::ACT_CLEAR,  32'h0, 48'd0, 8'd0, 1'b0, none);
    drain_results();

    // Random traffic in three stall profiles.
    src_idle = 24;
    snk_idle = 53;
    repeat (170) send_random();
    drain_results();
    src_idle = 53;
    snk_idle = 24;
    repeat (170) send_random();
    drain_results();
    src_idle = 0;
    snk_idle = 0;
    repeat (170) send_random();
    drain_results();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sparse_histogram_table_unit regression: pass");
    end else begin
      $display("sparse_histogram_table_unit regression: fail");
    end
    $finish;
  end

endmodule
